/* rtl/rpf_pkg.sv */
`timescale 1ns / 1ps

package rpf_pkg;

	// fixed field widths of the channels and registers, and the cloud-size bound
	localparam int THR_W     = 16;
	localparam int IDX_W     = 10;
	localparam int OUT_CNT_W = 11;
	localparam int MIN_CLOUD = 3;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_TRY   = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_LIMIT = 2'd2,
		STAT_BAD   = 2'd3
	} status_t;

	// register index (paddr[2])
	typedef enum logic {
		REG_THRESH = 1'b0,
		REG_TRIALS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_PLANE,
		S_RHS,
		S_SCAN,
		S_DRAIN,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic done;
		logic zero;
	} plane_stat_t;

	typedef struct packed {
		logic hit_valid;
		logic hit;
		logic busy;
	} eval_stat_t;

endpackage

/* rtl/rpf_if.sv */
`timescale 1ns / 1ps

interface rpf_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic signed [15:0] coord_z;
	logic [9:0]        first_index;
	logic [9:0]        second_index;
	logic [9:0]        third_index;

	modport source (output valid, mode, coord_x, coord_y, coord_z, first_index,
		second_index, third_index, input ready);
	modport sink (input valid, mode, coord_x, coord_y, coord_z, first_index,
		second_index, third_index, output ready);
endinterface

interface rpf_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [10:0] points_held;
	logic [10:0] trial_inliers;
	logic [10:0] best_inliers;
	logic        is_inlier;

	modport source (output valid, status, points_held, trial_inliers, best_inliers,
		is_inlier, input ready);
	modport sink (input valid, status, points_held, trial_inliers, best_inliers,
		is_inlier, output ready);
endinterface

/* rtl/rpf_ram.sv */
`timescale 1ns / 1ps

module rpf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/rpf_plane.sv */
`timescale 1ns / 1ps

// normal = (P2-P1) x (P3-P1), offset = -(n . P1); five stages
module rpf_plane #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [3*COORD_BITS-1:0]       p1,
	input  logic [3*COORD_BITS-1:0]       p2,
	input  logic [3*COORD_BITS-1:0]       p3,
	output logic signed [2*COORD_BITS+2:0] norm_a,
	output logic signed [2*COORD_BITS+2:0] norm_b,
	output logic signed [2*COORD_BITS+2:0] norm_c,
	output logic signed [3*COORD_BITS+5:0] offset,
	output rpf_pkg::plane_stat_t          stat
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int QW = 2 * DW;
	localparam int NW = 2 * CB + 3;
	localparam int PW = NW + CB;
	localparam int OW = PW + 3;

	logic signed [CB-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

	assign x1 = p1[CB-1:0];
	assign y1 = p1[2*CB-1:CB];
	assign z1 = p1[3*CB-1:2*CB];
	assign x2 = p2[CB-1:0];
	assign y2 = p2[2*CB-1:CB];
	assign z2 = p2[3*CB-1:2*CB];
	assign x3 = p3[CB-1:0];
	assign y3 = p3[2*CB-1:CB];
	assign z3 = p3[3*CB-1:2*CB];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [CB-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;
	logic signed [QW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [NW-1:0] a_s3, b_s3, c_s3, a_s4, b_s4, c_s4, a_s5, b_s5, c_s5;
	logic signed [PW-1:0] ax_s4, by_s4, cz_s4;
	logic signed [OW-1:0] d_s5;
	logic                 zero_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ux_s1 <= DW'(x2) - DW'(x1);
		uy_s1 <= DW'(y2) - DW'(y1);
		uz_s1 <= DW'(z2) - DW'(z1);
		vx_s1 <= DW'(x3) - DW'(x1);
		vy_s1 <= DW'(y3) - DW'(y1);
		vz_s1 <= DW'(z3) - DW'(z1);
		x_s1  <= x1;
		y_s1  <= y1;
		z_s1  <= z1;

		m0_s2 <= QW'(uy_s1) * QW'(vz_s1);
		m1_s2 <= QW'(uz_s1) * QW'(vy_s1);
		m2_s2 <= QW'(uz_s1) * QW'(vx_s1);
		m3_s2 <= QW'(ux_s1) * QW'(vz_s1);
		m4_s2 <= QW'(ux_s1) * QW'(vy_s1);
		m5_s2 <= QW'(uy_s1) * QW'(vx_s1);
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		z_s2  <= z_s1;

		a_s3 <= NW'(m0_s2) - NW'(m1_s2);
		b_s3 <= NW'(m2_s2) - NW'(m3_s2);
		c_s3 <= NW'(m4_s2) - NW'(m5_s2);
		x_s3 <= x_s2;
		y_s3 <= y_s2;
		z_s3 <= z_s2;

		ax_s4 <= PW'(a_s3) * PW'(x_s3);
		by_s4 <= PW'(b_s3) * PW'(y_s3);
		cz_s4 <= PW'(c_s3) * PW'(z_s3);
		a_s4  <= a_s3;
		b_s4  <= b_s3;
		c_s4  <= c_s3;

		d_s5    <= -(OW'(ax_s4) + OW'(by_s4) + OW'(cz_s4));
		a_s5    <= a_s4;
		b_s5    <= b_s4;
		c_s5    <= c_s4;
		zero_s5 <= (a_s4 == '0) && (b_s4 == '0) && (c_s4 == '0);
	end

	assign norm_a    = a_s5;
	assign norm_b    = b_s5;
	assign norm_c    = c_s5;
	assign offset    = d_s5;
	assign stat.done = v_s5;
	assign stat.zero = zero_s5;

endmodule

/* rtl/rpf_rhs.sv */
`timescale 1ns / 1ps

// t^2 * (A^2 + B^2 + C^2); squares split in halves, three stages
module rpf_rhs #(
	parameter int COORD_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic signed [2*COORD_BITS+2:0]              norm_a,
	input  logic signed [2*COORD_BITS+2:0]              norm_b,
	input  logic signed [2*COORD_BITS+2:0]              norm_c,
	input  logic [rpf_pkg::THR_W-1:0]                   thresh,
	output logic [2*(rpf_pkg::THR_W+2*COORD_BITS+3)+1:0] rhs,
	output logic                                        done
);

	localparam int NW = 2 * COORD_BITS + 3;
	localparam int TW = rpf_pkg::THR_W + NW;
	localparam int RW = 2 * TW + 2;
	localparam int H  = (TW + 1) / 2;
	localparam int HI = TW - H;

	logic v_s1, v_s2, v_s3;
	logic [NW-1:0]     mag [3];
	logic [TW-1:0]     ta_s1 [3];
	logic [2*HI-1:0]   hh_s2 [3];
	logic [TW-1:0]     hl_s2 [3];
	logic [2*H-1:0]    ll_s2 [3];
	logic [RW-1:0]     rhs_s3;
	logic [RW-1:0]     sum;

	always_comb begin
		mag[0] = norm_a[NW-1] ? NW'(-norm_a) : NW'(norm_a);
		mag[1] = norm_b[NW-1] ? NW'(-norm_b) : NW'(norm_b);
		mag[2] = norm_c[NW-1] ? NW'(-norm_c) : NW'(norm_c);
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			sum = sum + (RW'(hh_s2[k]) << (2 * H)) + (RW'(hl_s2[k]) << (H + 1))
				+ RW'(ll_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ta_s1[k] <= TW'(thresh) * TW'(mag[k]);
			hh_s2[k] <= (2*HI)'(ta_s1[k][TW-1:H]) * (2*HI)'(ta_s1[k][TW-1:H]);
			hl_s2[k] <= TW'(ta_s1[k][TW-1:H]) * TW'(ta_s1[k][H-1:0]);
			ll_s2[k] <= (2*H)'(ta_s1[k][H-1:0]) * (2*H)'(ta_s1[k][H-1:0]);
		end
		rhs_s3 <= sum;
	end

	assign rhs  = rhs_s3;
	assign done = v_s3;

endmodule

/* rtl/rpf_eval.sv */
`timescale 1ns / 1ps

// point-to-plane test |A x + B y + C z + D|^2 <= rhs; four stages, one point a cycle
module rpf_eval #(
	parameter int COORD_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        pt_valid,
	input  logic [3*COORD_BITS-1:0]                     point,
	input  logic signed [2*COORD_BITS+2:0]              norm_a,
	input  logic signed [2*COORD_BITS+2:0]              norm_b,
	input  logic signed [2*COORD_BITS+2:0]              norm_c,
	input  logic signed [3*COORD_BITS+5:0]              offset,
	input  logic [2*(rpf_pkg::THR_W+2*COORD_BITS+3)+1:0] rhs,
	output rpf_pkg::eval_stat_t                         stat
);

	localparam int CB  = COORD_BITS;
	localparam int NW  = 2 * CB + 3;
	localparam int PW  = NW + CB;
	localparam int OW  = PW + 3;
	localparam int SW  = OW + 1;
	localparam int H   = (SW + 1) / 2;
	localparam int HI  = SW - H;
	localparam int M2W = 2 * SW;
	localparam int RW  = 2 * (rpf_pkg::THR_W + NW) + 2;
	localparam int CMW = (M2W > RW) ? M2W : RW;

	logic signed [CB-1:0] px, py, pz;

	assign px = point[CB-1:0];
	assign py = point[2*CB-1:CB];
	assign pz = point[3*CB-1:2*CB];

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PW-1:0] ax_s1, by_s1, cz_s1;
	logic signed [SW-1:0] s;
	logic [SW-1:0]        m_s2;
	logic [2*HI-1:0]      hh_s3;
	logic [SW-1:0]        hl_s3;
	logic [2*H-1:0]       ll_s3;
	logic [M2W-1:0]       m2;
	logic                 hit_s4;

	assign s  = SW'(ax_s1) + SW'(by_s1) + SW'(cz_s1) + SW'(offset);
	assign m2 = (M2W'(hh_s3) << (2 * H)) + (M2W'(hl_s3) << (H + 1)) + M2W'(ll_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= PW'(norm_a) * PW'(px);
		by_s1  <= PW'(norm_b) * PW'(py);
		cz_s1  <= PW'(norm_c) * PW'(pz);
		m_s2   <= s[SW-1] ? SW'(-s) : SW'(s);
		hh_s3  <= (2*HI)'(m_s2[SW-1:H]) * (2*HI)'(m_s2[SW-1:H]);
		hl_s3  <= SW'(m_s2[SW-1:H]) * SW'(m_s2[H-1:0]);
		ll_s3  <= (2*H)'(m_s2[H-1:0]) * (2*H)'(m_s2[H-1:0]);
		hit_s4 <= CMW'(m2) <= CMW'(rhs);
	end

	assign stat.hit_valid = v_s4;
	assign stat.hit       = hit_s4;
	assign stat.busy      = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

/* rtl/ransac_plane_fit.sv */
`timescale 1ns / 1ps

// channel  dir  modport  payload
// cmd      in   sink     mode, coord_x/y/z, first/second/third_index
// res      out  source   status, points_held, trial_inliers, best_inliers, is_inlier
// apb      in   -        distance_threshold @0x0, max_trials @0x4
//
// From command transfer to result valid: load, clear, refused commands go to result;
//   degenerate: fetch, plane; query: threshold term, one read, distance pipeline;
//   hypothesis: fetch, plane, threshold term, RAM scan one point per cycle, drain.
// The command side is ready again in the cycle the result goes valid.
// Reset clears counters and best plane and sets the configuration registers to defaults;
// the point RAM needs no clearing. A held result does not block the next transfer; the next result waits for it.
module ransac_plane_fit #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rpf_cmd_if.sink    cmd,
	rpf_res_if.source  res,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int PTW  = 3 * COORD_BITS;
	localparam int NW   = 2 * COORD_BITS + 3;
	localparam int OW   = NW + COORD_BITS + 3;
	localparam int RW   = 2 * (rpf_pkg::THR_W + NW) + 2;
	localparam int CMAX = 2 ** (COORD_BITS - 1) - 1;
	localparam int CMIN = -(2 ** (COORD_BITS - 1));

	function automatic logic [COORD_BITS-1:0] sat(input logic signed [15:0] v);
		int w;
		w = int'(v);
		if (w > CMAX) begin
			w = CMAX;
		end else if (w < CMIN) begin
			w = CMIN;
		end
		return COORD_BITS'(w);
	endfunction

	rpf_pkg::state_t  state_q, state_d;
	rpf_pkg::status_t r_status_q;

	// configuration
	logic [15:0] thr_q, maxt_q;

	// block state
	logic [CW-1:0]        total_q, best_cnt_q;
	logic [15:0]          trials_q;
	logic signed [NW-1:0] best_a_q, best_b_q, best_c_q;
	logic signed [OW-1:0] best_d_q;

	// working plane and scan control
	logic signed [NW-1:0] wa_q, wb_q, wc_q;
	logic signed [OW-1:0] wd_q;
	logic [RW-1:0]        rhs_q;
	logic [AW-1:0]        i1_q, i2_q, i3_q, addr_q;
	logic [PTW-1:0]       p1_q, p2_q, p3_q;
	logic [1:0]           fcnt_q;
	logic                 kick_q, rd_v_q, is_query_q, r_inl_q;
	logic [CW-1:0]        left_q, cnt_q, r_trial_q;

	logic                 accept, full, try_bad, query_bad, drained, res_free;
	rpf_pkg::mode_t       mode;
	logic                 we;
	logic [AW-1:0]        raddr;
	logic [PTW-1:0]       rdata;

	rpf_pkg::plane_stat_t pstat;
	rpf_pkg::eval_stat_t  estat;
	logic signed [NW-1:0] pa, pb, pc;
	logic signed [OW-1:0] pd;
	logic [RW-1:0]        rhs;
	logic                 rhs_done;

	assign mode     = rpf_pkg::mode_t'(cmd.mode);
	assign accept   = cmd.valid && cmd.ready;
	assign full     = (total_q >= CW'(MAX_POINTS));
	assign drained  = !rd_v_q && !estat.busy;
	assign res_free = !res.valid || res.ready;

	// sample must be three distinct stored points of a cloud larger than three
	assign try_bad = (total_q <= CW'(rpf_pkg::MIN_CLOUD))
		|| (32'(cmd.first_index) >= 32'(total_q))
		|| (32'(cmd.second_index) >= 32'(total_q))
		|| (32'(cmd.third_index) >= 32'(total_q))
		|| (cmd.first_index == cmd.second_index)
		|| (cmd.first_index == cmd.third_index)
		|| (cmd.second_index == cmd.third_index);
	assign query_bad = (32'(cmd.first_index) >= 32'(total_q));

	// ---------------- point store ----------------
	assign we = accept && (mode == rpf_pkg::MODE_LOAD) && !full;

	always_comb begin
		case (fcnt_q)
			2'd0:    raddr = i1_q;
			2'd1:    raddr = i2_q;
			2'd2:    raddr = i3_q;
			default: raddr = addr_q;
		endcase
		if (state_q != rpf_pkg::S_FETCH) begin
			raddr = addr_q;
		end
	end

	rpf_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(total_q)),
		.wdata({sat(cmd.coord_z), sat(cmd.coord_y), sat(cmd.coord_x)}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// ---------------- arithmetic units ----------------
	rpf_plane #(.COORD_BITS(COORD_BITS)) u_plane (
		.clk   (clk),
		.arst_n(arst_n),
		.start (kick_q && (state_q == rpf_pkg::S_PLANE)),
		.p1    (p1_q),
		.p2    (p2_q),
		.p3    (p3_q),
		.norm_a(pa),
		.norm_b(pb),
		.norm_c(pc),
		.offset(pd),
		.stat  (pstat)
	);

	rpf_rhs #(.COORD_BITS(COORD_BITS)) u_rhs (
		.clk   (clk),
		.arst_n(arst_n),
		.start (kick_q && (state_q == rpf_pkg::S_RHS)),
		.norm_a(wa_q),
		.norm_b(wb_q),
		.norm_c(wc_q),
		.thresh(thr_q),
		.rhs   (rhs),
		.done  (rhs_done)
	);

	rpf_eval #(.COORD_BITS(COORD_BITS)) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.pt_valid(rd_v_q),
		.point   (rdata),
		.norm_a  (wa_q),
		.norm_b  (wb_q),
		.norm_c  (wc_q),
		.offset  (wd_q),
		.rhs     (rhs_q),
		.stat    (estat)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = (state_q == rpf_pkg::S_IDLE);
		case (state_q)
			rpf_pkg::S_IDLE: begin
				if (accept) begin
					case (mode)
						rpf_pkg::MODE_TRY: begin
							if (trials_q >= maxt_q || try_bad) begin
								state_d = rpf_pkg::S_RESULT;
							end else begin
								state_d = rpf_pkg::S_FETCH;
							end
						end
						rpf_pkg::MODE_QUERY: begin
							if (query_bad || best_cnt_q == '0) begin
								state_d = rpf_pkg::S_RESULT;
							end else begin
								state_d = rpf_pkg::S_RHS;
							end
						end
						default: state_d = rpf_pkg::S_RESULT;
					endcase
				end
			end
			rpf_pkg::S_FETCH: begin
				if (fcnt_q == 2'd3) begin
					state_d = rpf_pkg::S_PLANE;
				end
			end
			rpf_pkg::S_PLANE: begin
				if (pstat.done) begin
					state_d = pstat.zero ? rpf_pkg::S_RESULT : rpf_pkg::S_RHS;
				end
			end
			rpf_pkg::S_RHS: begin
				if (rhs_done) begin
					state_d = rpf_pkg::S_SCAN;
				end
			end
			rpf_pkg::S_SCAN: begin
				if (left_q == CW'(1)) begin
					state_d = rpf_pkg::S_DRAIN;
				end
			end
			rpf_pkg::S_DRAIN: begin
				if (drained) begin
					state_d = rpf_pkg::S_RESULT;
				end
			end
			rpf_pkg::S_RESULT: begin
				if (res_free) begin
					state_d = rpf_pkg::S_IDLE;
				end
			end
			default: state_d = rpf_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= 16'd256;
			maxt_q     <= 16'd100;
			total_q    <= '0;
			best_cnt_q <= '0;
			trials_q   <= '0;
			best_a_q   <= '0;
			best_b_q   <= '0;
			best_c_q   <= '0;
			best_d_q   <= '0;
			fcnt_q     <= '0;
			kick_q     <= 1'b0;
			rd_v_q     <= 1'b0;
			left_q     <= '0;
			cnt_q      <= '0;
			is_query_q <= 1'b0;
			res.valid  <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			rd_v_q <= (state_q == rpf_pkg::S_SCAN);

			if (psel && penable && pwrite) begin
				case (rpf_pkg::reg_idx_t'(paddr[2]))
					rpf_pkg::REG_THRESH: thr_q  <= pwdata[15:0];
					rpf_pkg::REG_TRIALS: maxt_q <= pwdata[15:0];
					default: ;
				endcase
			end

			if (estat.hit_valid && estat.hit) begin
				cnt_q <= cnt_q + CW'(1);
			end

			case (state_q)
				rpf_pkg::S_IDLE: begin
					if (accept) begin
						fcnt_q <= '0;
						case (mode)
							rpf_pkg::MODE_LOAD: begin
								if (!full) begin
									total_q <= total_q + CW'(1);
								end
							end
							rpf_pkg::MODE_TRY: begin
								is_query_q <= 1'b0;
								if (trials_q < maxt_q) begin
									trials_q <= trials_q + 16'd1;
								end
							end
							rpf_pkg::MODE_QUERY: begin
								is_query_q <= 1'b1;
								left_q     <= CW'(1);
								cnt_q      <= '0;
								kick_q     <= !query_bad && (best_cnt_q != '0);
							end
							rpf_pkg::MODE_CLEAR: begin
								total_q    <= '0;
								best_cnt_q <= '0;
								trials_q   <= '0;
								best_a_q   <= '0;
								best_b_q   <= '0;
								best_c_q   <= '0;
								best_d_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				rpf_pkg::S_FETCH: begin
					fcnt_q <= fcnt_q + 2'd1;
					kick_q <= (fcnt_q == 2'd3);
				end
				rpf_pkg::S_PLANE: begin
					if (pstat.done && !pstat.zero) begin
						kick_q <= 1'b1;
					end
				end
				rpf_pkg::S_RHS: begin
					if (rhs_done && !is_query_q) begin
						left_q <= total_q;
						cnt_q  <= '0;
					end
				end
				rpf_pkg::S_SCAN: begin
					left_q <= left_q - CW'(1);
				end
				rpf_pkg::S_DRAIN: begin
					// strictly greater count replaces the best plane
					if (drained && !is_query_q && cnt_q > best_cnt_q) begin
						best_cnt_q <= cnt_q;
						best_a_q   <= wa_q;
						best_b_q   <= wb_q;
						best_c_q   <= wc_q;
						best_d_q   <= wd_q;
					end
				end
				default: ;
			endcase

			if (state_q == rpf_pkg::S_RESULT && res_free) begin
				res.valid <= 1'b1;
			end else if (res.ready) begin
				res.valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			rpf_pkg::S_IDLE: begin
				if (accept) begin
					i1_q      <= AW'(cmd.first_index);
					i2_q      <= AW'(cmd.second_index);
					i3_q      <= AW'(cmd.third_index);
					addr_q    <= AW'(cmd.first_index);
					r_status_q <= rpf_pkg::STAT_OK;
					r_trial_q <= '0;
					r_inl_q   <= 1'b0;
					wa_q      <= best_a_q;
					wb_q      <= best_b_q;
					wc_q      <= best_c_q;
					wd_q      <= best_d_q;
					case (mode)
						rpf_pkg::MODE_LOAD: begin
							if (full) begin
								r_status_q <= rpf_pkg::STAT_FULL;
							end
						end
						rpf_pkg::MODE_TRY: begin
							if (trials_q >= maxt_q) begin
								r_status_q <= rpf_pkg::STAT_LIMIT;
							end else if (try_bad) begin
								r_status_q <= rpf_pkg::STAT_BAD;
							end
						end
						rpf_pkg::MODE_QUERY: begin
							if (query_bad) begin
								r_status_q <= rpf_pkg::STAT_BAD;
							end
						end
						default: ;
					endcase
				end
			end
			rpf_pkg::S_FETCH: begin
				case (fcnt_q)
					2'd1:    p1_q <= rdata;
					2'd2:    p2_q <= rdata;
					2'd3:    p3_q <= rdata;
					default: ;
				endcase
			end
			rpf_pkg::S_PLANE: begin
				if (pstat.done) begin
					if (pstat.zero) begin
						r_status_q <= rpf_pkg::STAT_BAD;
					end
					wa_q <= pa;
					wb_q <= pb;
					wc_q <= pc;
					wd_q <= pd;
				end
			end
			rpf_pkg::S_RHS: begin
				if (rhs_done) begin
					rhs_q <= rhs;
					if (!is_query_q) begin
						addr_q <= '0;
					end
				end
			end
			rpf_pkg::S_SCAN: begin
				addr_q <= addr_q + AW'(1);
			end
			rpf_pkg::S_DRAIN: begin
				if (drained) begin
					if (is_query_q) begin
						r_inl_q <= (cnt_q != '0);
					end else begin
						r_trial_q <= cnt_q;
					end
				end
			end
			default: ;
		endcase

		if (state_q == rpf_pkg::S_RESULT && res_free) begin
			res.status        <= r_status_q;
			res.points_held   <= rpf_pkg::OUT_CNT_W'(total_q);
			res.trial_inliers <= rpf_pkg::OUT_CNT_W'(r_trial_q);
			res.best_inliers  <= rpf_pkg::OUT_CNT_W'(best_cnt_q);
			res.is_inlier     <= r_inl_q;
		end
	end

	// ---------------- register read ----------------
	assign pready = 1'b1;

	always_comb begin
		case (rpf_pkg::reg_idx_t'(paddr[2]))
			rpf_pkg::REG_THRESH: prdata = {16'd0, thr_q};
			rpf_pkg::REG_TRIALS: prdata = {16'd0, maxt_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------- checks ----------------
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_POINTS))
		else $error("point count above store depth");

	a_best_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		best_cnt_q <= total_q)
		else $error("best count above point count");

	a_plane_done: assert property (@(posedge clk) disable iff (!arst_n)
		pstat.done |-> state_q == rpf_pkg::S_PLANE)
		else $error("plane unit finished outside plane step");

	a_rhs_done: assert property (@(posedge clk) disable iff (!arst_n)
		rhs_done |-> state_q == rpf_pkg::S_RHS)
		else $error("threshold unit finished outside its step");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpf_pkg::S_IDLE |-> !rd_v_q && !estat.busy)
		else $error("distance pipeline busy while idle");

endmodule
